>>> design/basr_pkg.sv
// bridge ADC serial reader package: word types, phase codes, timing constants
// and the divider request/result structs; no dependencies
package basr_pkg;

    localparam int DATA_BITS = 24;
    localparam int CNT_W = $clog2(DATA_BITS + 3);

    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_WAIT_HIGH = 4'd1;
    localparam logic [3:0] PH_WAIT_LOW = 4'd2;
    localparam logic [3:0] PH_CLK_RISE = 4'd3;
    localparam logic [3:0] PH_CLK_FALL = 4'd4;
    localparam logic [3:0] PH_DIV_AVG = 4'd5;
    localparam logic [3:0] PH_DIV_UNITS = 4'd6;
    localparam logic [3:0] PH_OUT = 4'd7;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_MEASURE = 2'd1;
    localparam logic [1:0] CMD_TARE = 2'd2;
    localparam logic [1:0] CMD_LOAD_OFFSET = 2'd3;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_TIMEOUT_HIGH = 2'd1;
    localparam logic [1:0] ERR_TIMEOUT_LOW = 2'd2;
    localparam logic [1:0] ERR_DIV_ZERO = 2'd3;

    localparam logic [10:0] LIMIT_FAST = 11'd620;
    localparam logic [10:0] LIMIT_SLOW = 11'd750;
    localparam logic [10:0] LIMIT_FAST_CAL = 11'd750;
    localparam logic [10:0] LIMIT_SLOW_CAL = 11'd1450;

    localparam logic [1:0] REG_SPEED = 2'd0;
    localparam logic [1:0] REG_CAL = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;
    localparam logic [1:0] REG_SCALE = 2'd3;

    // dividend/divisor widths of the shared serial divider
    localparam int DIV_NW = 56;
    localparam int DIV_DW = 32;

    typedef struct packed {
        logic [1:0] command;
        logic dout_level;
        logic ms_tick;
        logic signed [31:0] offset_value;
    } in_word_t;

    typedef struct packed {
        logic sclk;
        logic busy_res;
        logic done_res;
        logic [1:0] error_code;
        logic signed [31:0] average;
        logic signed [39:0] units;
    } out_word_t;

    typedef struct packed {
        logic start;
        logic [DIV_NW-1:0] num_mag;
        logic [DIV_DW-1:0] den_mag;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic [DIV_NW-1:0] quot;
    } div_rsp_t;

endpackage

>>> design/basr_divider.sv
// bit-serial restoring divider for unsigned magnitudes, one quotient bit a cycle
// depends on basr_pkg
module basr_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  basr_pkg::div_req_t req,
    output basr_pkg::div_rsp_t rsp
);

    localparam int NW = basr_pkg::DIV_NW;
    localparam int DW = basr_pkg::DIV_DW;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quot_reg;
    logic [NW-1:0] quot_next;
    logic [DW:0] rem_reg;
    logic [DW:0] rem_next;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] den_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic busy_reg;
    logic busy_next;
    logic [DW+1:0] trial;
    logic [DW:0] shifted;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        shifted = {rem_reg[DW-1:0], quot_reg[NW-1]};
        trial = {1'b0, shifted} - {2'b00, den_reg};
        if (req.start)
        begin
            quot_next = req.num_mag;
            rem_next = '0;
            den_next = req.den_mag;
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DW+1])
            begin
                rem_next = trial[DW:0];
                quot_next = {quot_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quot_next = {quot_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.quot = quot_reg;

endmodule

>>> design/basr_regs.sv
// configuration registers behind the APB-style port
// depends on basr_pkg
module basr_regs
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        speed_fast,
    output logic        calibrating,
    output logic [7:0]  sample_count,
    output logic [31:0] scale
);

    logic speed_reg;
    logic cal_reg;
    logic [7:0] count_reg;
    logic [31:0] scale_reg;
    logic wr_en;

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= 1'b0;
            cal_reg <= 1'b0;
            count_reg <= 8'd1;
            scale_reg <= 32'd65536;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[3:2])
                basr_pkg::REG_SPEED: speed_reg <= pwdata[0];
                basr_pkg::REG_CAL: cal_reg <= pwdata[0];
                basr_pkg::REG_COUNT: count_reg <= pwdata[7:0];
                basr_pkg::REG_SCALE: scale_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            basr_pkg::REG_SPEED: prdata = {31'd0, speed_reg};
            basr_pkg::REG_CAL: prdata = {31'd0, cal_reg};
            basr_pkg::REG_COUNT: prdata = {24'd0, count_reg};
            basr_pkg::REG_SCALE: prdata = scale_reg;
            default: prdata = '0;
        endcase
    end

    assign speed_fast = speed_reg;
    assign calibrating = cal_reg;
    assign sample_count = count_reg;
    assign scale = scale_reg;

endmodule

>>> design/bridge_adc_serial_reader_core.sv
// top level of the bridge ADC serial reader: step sequencer, serial shifter,
// final average/units division; depends on basr_pkg, basr_regs, basr_divider
//
//  channel | direction | handshake     | payload
//  in      | input     | in_valid/ready | basr_pkg::in_word_t
//  out     | output    | out_valid/ready| basr_pkg::out_word_t
//  apb     | input     | psel/penable   | 4 registers at 4*i
//
// a time step is accepted while in_ready; a finishing step runs the average
// and, bar a tare or a zero scale, the units division on the shared serial
// divider; one result word per step sits in the output register until taken
// reset clears the sequencer and configuration to their defaults
module bridge_adc_serial_reader_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  basr_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output basr_pkg::out_word_t  out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int DB = basr_pkg::DATA_BITS;
    localparam int CW = basr_pkg::CNT_W;
    localparam int NW = basr_pkg::DIV_NW;

    logic speed_fast;
    logic calibrating;
    logic [7:0] sample_count;
    logic [31:0] scale;

    basr_pkg::div_req_t div_req;
    basr_pkg::div_rsp_t div_rsp;

    logic [3:0] phase_reg, phase_next;
    logic [10:0] timer_reg, timer_next;
    logic [CW-1:0] bit_reg, bit_next;
    logic [DB-1:0] shift_reg, shift_next;
    logic [31:0] sum_reg, sum_next;
    logic [7:0] done_cnt_reg, done_cnt_next;
    logic [31:0] offset_reg, offset_next;
    logic tare_reg, tare_next;
    logic div_go_reg, div_go_next;
    logic neg_reg, neg_next;
    logic signed [31:0] avg_reg, avg_next;
    logic out_valid_reg, out_valid_next;
    basr_pkg::out_word_t out_reg, out_next;

    logic [10:0] limit;
    logic [31:0] sum_new;
    logic signed [32:0] sum_mag_s;
    logic signed [40:0] avg_wide;
    logic signed [32:0] diff;
    logic [32:0] diff_mag;
    logic [31:0] scale_mag;
    logic signed [56:0] units_wide;
    logic [DB-1:0] shift_in;
    logic accept;

    assign pready = 1'b1;

    basr_regs u_regs
    (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .speed_fast(speed_fast),
        .calibrating(calibrating), .sample_count(sample_count), .scale(scale)
    );

    basr_divider u_div
    (
        .clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp)
    );

    assign in_ready = (phase_reg == basr_pkg::PH_IDLE || phase_reg == basr_pkg::PH_WAIT_HIGH
        || phase_reg == basr_pkg::PH_WAIT_LOW || phase_reg == basr_pkg::PH_CLK_RISE
        || phase_reg == basr_pkg::PH_CLK_FALL) && (!out_valid_reg || out_ready);
    assign accept = in_valid && in_ready;

    always_comb
    begin
        if (calibrating)
        begin
            limit = speed_fast ? basr_pkg::LIMIT_FAST_CAL : basr_pkg::LIMIT_SLOW_CAL;
        end
        else
        begin
            limit = speed_fast ? basr_pkg::LIMIT_FAST : basr_pkg::LIMIT_SLOW;
        end
    end

    assign shift_in = {shift_reg[DB-2:0], in_data.dout_level};
    assign sum_new = sum_reg + 32'(signed'(shift_reg));
    assign diff = 33'(avg_reg) - 33'(signed'(offset_reg));
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    assign scale_mag = scale[31] ? 32'(-scale) : scale;
    assign avg_wide = neg_reg ? -41'(div_rsp.quot[39:0]) : 41'(div_rsp.quot[39:0]);
    assign units_wide = neg_reg ? -57'(div_rsp.quot) : 57'(div_rsp.quot);
    assign sum_mag_s = sum_reg[31] ? -33'(signed'(sum_reg)) : 33'(signed'(sum_reg));

    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        bit_next = bit_reg;
        shift_next = shift_reg;
        sum_next = sum_reg;
        done_cnt_next = done_cnt_reg;
        offset_next = offset_reg;
        tare_next = tare_reg;
        div_go_next = 1'b0;
        neg_next = neg_reg;
        avg_next = avg_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        div_req.start = div_go_reg;
        div_req.num_mag = '0;
        div_req.den_mag = '0;
        if (phase_reg == basr_pkg::PH_DIV_AVG)
        begin
            div_req.num_mag = NW'({sum_mag_s[32:0], 8'd0});
            div_req.den_mag = 32'(done_cnt_reg);
        end
        else
        begin
            div_req.num_mag = NW'({diff_mag, 16'd0});
            div_req.den_mag = scale_mag;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_next = '0;
            unique case (phase_reg)
                basr_pkg::PH_IDLE:
                begin
                    if (in_data.command == basr_pkg::CMD_MEASURE
                        || in_data.command == basr_pkg::CMD_TARE)
                    begin
                        if (sample_count == 8'd0)
                        begin
                            out_next.done_res = 1'b1;
                            out_next.error_code = basr_pkg::ERR_DIV_ZERO;
                        end
                        else
                        begin
                            tare_next = (in_data.command == basr_pkg::CMD_TARE);
                            phase_next = basr_pkg::PH_WAIT_HIGH;
                            timer_next = '0;
                            sum_next = '0;
                            done_cnt_next = '0;
                        end
                    end
                    else if (in_data.command == basr_pkg::CMD_LOAD_OFFSET)
                    begin
                        offset_next = in_data.offset_value;
                    end
                end
                basr_pkg::PH_WAIT_HIGH, basr_pkg::PH_WAIT_LOW:
                begin
                    if (in_data.dout_level == (phase_reg == basr_pkg::PH_WAIT_HIGH))
                    begin
                        timer_next = '0;
                        if (phase_reg == basr_pkg::PH_WAIT_HIGH)
                        begin
                            phase_next = basr_pkg::PH_WAIT_LOW;
                        end
                        else
                        begin
                            phase_next = basr_pkg::PH_CLK_RISE;
                            shift_next = '0;
                            bit_next = '0;
                        end
                    end
                    else if (in_data.ms_tick)
                    begin
                        timer_next = timer_reg + 1'b1;
                        if (timer_reg + 1'b1 > limit)
                        begin
                            out_next.done_res = 1'b1;
                            out_next.error_code = (phase_reg == basr_pkg::PH_WAIT_HIGH)
                                ? basr_pkg::ERR_TIMEOUT_HIGH : basr_pkg::ERR_TIMEOUT_LOW;
                            phase_next = basr_pkg::PH_IDLE;
                            timer_next = '0;
                        end
                    end
                end
                basr_pkg::PH_CLK_RISE:
                begin
                    out_next.sclk = 1'b1;
                    phase_next = basr_pkg::PH_CLK_FALL;
                end
                basr_pkg::PH_CLK_FALL:
                begin
                    if (bit_reg < CW'(DB))
                    begin
                        shift_next = shift_in;
                    end
                    bit_next = bit_reg + 1'b1;
                    phase_next = basr_pkg::PH_CLK_RISE;
                    if (bit_reg + 1'b1 >= CW'(DB) + (calibrating ? CW'(2) : CW'(1)))
                    begin
                        sum_next = sum_new;
                        done_cnt_next = done_cnt_reg + 1'b1;
                        if (done_cnt_reg + 1'b1 >= sample_count)
                        begin
                            phase_next = basr_pkg::PH_DIV_AVG;
                            div_go_next = 1'b1;
                            neg_next = sum_new[31];
                            out_valid_next = 1'b0;
                        end
                        else
                        begin
                            phase_next = basr_pkg::PH_WAIT_HIGH;
                            timer_next = '0;
                        end
                    end
                end
                default: ;
            endcase
            out_next.busy_res = (phase_next != basr_pkg::PH_IDLE);
        end
        else if (phase_reg == basr_pkg::PH_DIV_AVG && !div_go_reg && !div_rsp.busy)
        begin
            if (avg_wide > 41'sd2147483647)
            begin
                avg_next = 32'sh7fffffff;
            end
            else if (avg_wide < -41'sd2147483648)
            begin
                avg_next = 32'sh80000000;
            end
            else
            begin
                avg_next = avg_wide[31:0];
            end
            phase_next = basr_pkg::PH_DIV_UNITS;
        end
        else if (phase_reg == basr_pkg::PH_DIV_UNITS && !div_go_reg && !div_rsp.busy)
        begin
            if (tare_reg || scale == 32'd0)
            begin
                phase_next = basr_pkg::PH_OUT;
            end
            else
            begin
                div_go_next = 1'b1;
                neg_next = diff[32] ^ scale[31];
                phase_next = basr_pkg::PH_OUT;
            end
        end
        else if (phase_reg == basr_pkg::PH_OUT && !div_go_reg && !div_rsp.busy)
        begin
            out_next = '0;
            out_next.done_res = 1'b1;
            out_next.average = avg_reg;
            if (tare_reg)
            begin
                offset_next = avg_reg;
            end
            else if (scale == 32'd0)
            begin
                out_next.error_code = basr_pkg::ERR_DIV_ZERO;
            end
            else if (units_wide > 57'sd549755813887)
            begin
                out_next.units = 40'sh7fffffffff;
            end
            else if (units_wide < -57'sd549755813888)
            begin
                out_next.units = 40'sh8000000000;
            end
            else
            begin
                out_next.units = units_wide[39:0];
            end
            out_valid_next = 1'b1;
            phase_next = basr_pkg::PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= basr_pkg::PH_IDLE;
            timer_reg <= '0;
            bit_reg <= '0;
            shift_reg <= '0;
            sum_reg <= '0;
            done_cnt_reg <= '0;
            offset_reg <= '0;
            tare_reg <= 1'b0;
            div_go_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            bit_reg <= bit_next;
            shift_reg <= shift_next;
            sum_reg <= sum_next;
            done_cnt_reg <= done_cnt_next;
            offset_reg <= offset_next;
            tare_reg <= tare_next;
            div_go_reg <= div_go_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        avg_reg <= avg_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule

>>> design/basr_checker.sv
// port-level checker for the bridge ADC serial reader, bound to the top level
// depends on basr_pkg
module basr_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  basr_pkg::out_word_t out_data,
    input  logic                pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word dropped or changed while stalled");

    a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("word taken while result waits");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |-> !out_data.busy_res)
        else $error("finished word still busy");

    a_err_no_units: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error_code != basr_pkg::ERR_NONE |-> out_data.units == 40'd0)
        else $error("units on error");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind bridge_adc_serial_reader_core basr_checker u_basr_checker
(
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data), .pready(pready)
);
